### sv/gdsm_pkg.sv
// ----------------------------------------------------------------------------
// Derivative-of-Gaussian spectrum multiplier: shared package
// Widths, register map, pipeline depths, reset values and the exponential
// lookup table used across the filter datapath.
// ----------------------------------------------------------------------------
package gdsm_pkg;

  // Geometry and table size.
  localparam int MAX_SIDE       = 4096;
  localparam int EXP_TABLE_BITS = 8;
  localparam int EXP_TABLE_SIZE = 1 << EXP_TABLE_BITS;

  // Field widths.
  localparam int IDX_W    = 12;
  localparam int CENTER_W = 12;
  localparam int SCALE_W  = 32;
  localparam int BIN_W    = 48;
  localparam int HALF_W   = BIN_W / 2;

  // Configuration port.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Fixed-point datapath widths.
  localparam int FRAC_W     = 16;
  localparam int LOG2E_W    = 17;
  localparam int TWOPI_W    = 19;
  localparam int SHIFT_W    = 5;
  localparam int D_W        = 2 * IDX_W + 1;
  localparam int SP_W       = SCALE_W + D_W;
  localparam int X_W        = SP_W - FRAC_W;
  localparam int YP_W       = X_W + LOG2E_W;
  localparam int EXP_W      = 33;
  localparam int WC_W       = IDX_W + TWOPI_W;
  localparam int GP_W       = WC_W + EXP_W;
  localparam int GAIN_SHIFT = 24;
  localparam int G_W        = GP_W - GAIN_SHIFT;
  localparam int PP_W       = HALF_W + G_W;

  // Pipeline depths.
  localparam int GAIN_STAGES = 6;
  localparam int MUL_STAGES  = 3;
  localparam int LATENCY     = GAIN_STAGES + MUL_STAGES;

  // Arithmetic constants.
  localparam logic [LOG2E_W-1:0] LOG2E_Q16  = 17'd94548;
  localparam logic [TWOPI_W-1:0] TWO_PI_Q16 = 19'd411775;
  localparam logic [IDX_W-1:0]   SIDE_LAST  = IDX_W'(MAX_SIDE - 1);

  localparam logic [BIN_W-1:0] OUT_MAX = {1'b0, {(BIN_W-1){1'b1}}};
  localparam logic [BIN_W-1:0] OUT_MIN = {1'b1, {(BIN_W-1){1'b0}}};
  localparam logic [PP_W-1:0]  POS_LIM = PP_W'(OUT_MAX);
  localparam logic [PP_W-1:0]  NEG_LIM = PP_W'(OUT_MIN);

  // Register reset values.
  localparam logic [CENTER_W-1:0] CENTER_U_RST = 12'd256;
  localparam logic [CENTER_W-1:0] CENTER_V_RST = 12'd256;
  localparam logic [SCALE_W-1:0]  SCALE_RST    = 32'd8478000;
  localparam logic                DIR_RST      = 1'b0;

  typedef enum logic [1:0] {
    REG_CENTER_U  = 2'd0,
    REG_CENTER_V  = 2'd1,
    REG_EXP_SCALE = 2'd2,
    REG_DIRECTION = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [CENTER_W-1:0] center_u;
    logic [CENTER_W-1:0] center_v;
    logic [SCALE_W-1:0]  exponent_scale;
    logic                direction;
  } cfg_t;

  typedef struct packed {
    logic [BIN_W-1:0] re_mag;
    logic [BIN_W-1:0] im_mag;
    logic             re_neg;
    logic             im_neg;
  } bin_t;

  typedef struct packed {
    logic [G_W-1:0] g_mag;
    logic           g_neg;
  } gain_t;

  typedef logic [EXP_TABLE_SIZE-1:0][EXP_W-1:0] exp_tab_t;

  // Bitwise integer square root, floor.
  function automatic logic [63:0] isqrt64(logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bits;
    rem  = x;
    res  = 64'd0;
    bits = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bits) begin
        rem = rem - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res = res >> 1;
      end
      bits = bits >> 2;
    end
    return res;
  endfunction

  // Entry i holds 2^(-i/EXP_TABLE_SIZE) in Q.32, built by repeated rounding
  // multiplication with the EXP_TABLE_SIZE-th root of one half.
  function automatic exp_tab_t build_exp_table();
    exp_tab_t    tab;
    logic [63:0] r;
    logic [63:0] t;
    r = 64'd1 << 31;
    for (int i = 0; i < EXP_TABLE_BITS; i++) begin
      r = isqrt64(r << 32);
    end
    t      = 64'd1 << 32;
    tab[0] = EXP_W'(t);
    for (int i = 1; i < EXP_TABLE_SIZE; i++) begin
      t      = (t * r + (64'd1 << 31)) >> 32;
      tab[i] = EXP_W'(t);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TABLE = build_exp_table();

endpackage

### sv/gdsm_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the spectrum center, the exponent scale
// and the derivative direction.
// ----------------------------------------------------------------------------
module gdsm_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gdsm_pkg::ADDR_W-1:0]    paddr,
  input  logic [gdsm_pkg::DATA_W-1:0]    pwdata,
  output logic [gdsm_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  output gdsm_pkg::cfg_t                 cfg_o
);

  gdsm_pkg::cfg_t     cfg_q;
  gdsm_pkg::reg_idx_e reg_idx;
  logic               wr_en;

  assign reg_idx = gdsm_pkg::reg_idx_e'(paddr[gdsm_pkg::ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_u       <= gdsm_pkg::CENTER_U_RST;
      cfg_q.center_v       <= gdsm_pkg::CENTER_V_RST;
      cfg_q.exponent_scale <= gdsm_pkg::SCALE_RST;
      cfg_q.direction      <= gdsm_pkg::DIR_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        gdsm_pkg::REG_CENTER_U: begin
          cfg_q.center_u <= pwdata[gdsm_pkg::CENTER_W-1:0];
        end
        gdsm_pkg::REG_CENTER_V: begin
          cfg_q.center_v <= pwdata[gdsm_pkg::CENTER_W-1:0];
        end
        gdsm_pkg::REG_EXP_SCALE: begin
          cfg_q.exponent_scale <= pwdata[gdsm_pkg::SCALE_W-1:0];
        end
        gdsm_pkg::REG_DIRECTION: begin
          cfg_q.direction <= pwdata[0];
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      gdsm_pkg::REG_CENTER_U:  prdata = gdsm_pkg::DATA_W'(cfg_q.center_u);
      gdsm_pkg::REG_CENTER_V:  prdata = gdsm_pkg::DATA_W'(cfg_q.center_v);
      gdsm_pkg::REG_EXP_SCALE: prdata = gdsm_pkg::DATA_W'(cfg_q.exponent_scale);
      gdsm_pkg::REG_DIRECTION: prdata = gdsm_pkg::DATA_W'(cfg_q.direction);
    endcase
  end

endmodule

### sv/gdsm_gain_pipe.sv
// ----------------------------------------------------------------------------
// Gain pipeline
// Six-stage pipeline that turns a bin position into the signed real gain
// 2*pi*W*exp(-k*(U^2+V^2)) in Q.24.
// ----------------------------------------------------------------------------
module gdsm_gain_pipe (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic [gdsm_pkg::IDX_W-1:0]      column_index_i,
  input  logic [gdsm_pkg::IDX_W-1:0]      row_index_i,
  input  gdsm_pkg::cfg_t                  cfg_i,
  output logic                            valid_o,
  output gdsm_pkg::gain_t                 gain_o
);

  logic [gdsm_pkg::GAIN_STAGES-1:0] valid_q, valid_d;

  // Stage 1: offsets from the spectrum center.
  logic [gdsm_pkg::IDX_W-1:0] col, row;
  logic                       u_neg, v_neg;
  logic [gdsm_pkg::IDX_W-1:0] u_mag, v_mag;
  logic [gdsm_pkg::IDX_W-1:0] u1_q, v1_q, w1_q;
  logic                       wneg1_q;

  // Stage 2: squared radius and 2*pi*|W|.
  logic [gdsm_pkg::D_W-1:0]  u_ext, v_ext, d;
  logic [gdsm_pkg::WC_W-1:0] w_ext, wc;
  logic [gdsm_pkg::D_W-1:0]  d2_q;
  logic [gdsm_pkg::WC_W-1:0] wc2_q;
  logic                      wneg2_q;

  // Stage 3: k*D in Q.16.
  logic [gdsm_pkg::SP_W-1:0] scale_ext, d_ext, sp;
  logic [gdsm_pkg::X_W-1:0]  x3_q;
  logic [gdsm_pkg::WC_W-1:0] wc3_q;
  logic                      wneg3_q;

  // Stage 4: base-2 exponent split into shift and table index.
  logic [gdsm_pkg::YP_W-1:0]           x_ext, yp;
  logic                                in_range;
  logic                                rng4_q;
  logic [gdsm_pkg::SHIFT_W-1:0]        sh4_q;
  logic [gdsm_pkg::EXP_TABLE_BITS-1:0] idx4_q;
  logic [gdsm_pkg::WC_W-1:0]           wc4_q;
  logic                                wneg4_q;

  // Stage 5: exponential.
  logic [gdsm_pkg::EXP_W-1:0] e;
  logic [gdsm_pkg::EXP_W-1:0] e5_q;
  logic [gdsm_pkg::WC_W-1:0]  wc5_q;
  logic                       wneg5_q;

  // Stage 6: gain.
  logic [gdsm_pkg::GP_W-1:0] wc_ext, e_ext, gp;
  gdsm_pkg::gain_t           gain6_q;

  assign valid_d = {valid_q[gdsm_pkg::GAIN_STAGES-2:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_comb begin
    col   = (column_index_i > gdsm_pkg::SIDE_LAST) ? gdsm_pkg::SIDE_LAST : column_index_i;
    row   = (row_index_i > gdsm_pkg::SIDE_LAST) ? gdsm_pkg::SIDE_LAST : row_index_i;
    u_neg = col < cfg_i.center_u;
    v_neg = row < cfg_i.center_v;
    u_mag = u_neg ? cfg_i.center_u - col : col - cfg_i.center_u;
    v_mag = v_neg ? cfg_i.center_v - row : row - cfg_i.center_v;
  end

  assign u_ext = gdsm_pkg::D_W'(u1_q);
  assign v_ext = gdsm_pkg::D_W'(v1_q);
  assign d     = u_ext * u_ext + v_ext * v_ext;
  assign w_ext = gdsm_pkg::WC_W'(w1_q);
  assign wc    = w_ext * gdsm_pkg::WC_W'(gdsm_pkg::TWO_PI_Q16);

  assign scale_ext = gdsm_pkg::SP_W'(cfg_i.exponent_scale);
  assign d_ext     = gdsm_pkg::SP_W'(d2_q);
  assign sp        = scale_ext * d_ext;

  assign x_ext    = gdsm_pkg::YP_W'(x3_q);
  assign yp       = x_ext * gdsm_pkg::YP_W'(gdsm_pkg::LOG2E_Q16);
  // The integer part of the exponent must stay below 32, else the result flushes.
  assign in_range = (yp[gdsm_pkg::YP_W-1:2*gdsm_pkg::FRAC_W+gdsm_pkg::SHIFT_W] == '0);

  assign e = rng4_q ? (gdsm_pkg::EXP_TABLE[idx4_q] >> sh4_q) : '0;

  assign wc_ext = gdsm_pkg::GP_W'(wc5_q);
  assign e_ext  = gdsm_pkg::GP_W'(e5_q);
  assign gp     = wc_ext * e_ext;

  always_ff @(posedge clk_i) begin
    u1_q    <= u_mag;
    v1_q    <= v_mag;
    w1_q    <= cfg_i.direction ? v_mag : u_mag;
    wneg1_q <= cfg_i.direction ? v_neg : u_neg;

    d2_q    <= d;
    wc2_q   <= wc;
    wneg2_q <= wneg1_q;

    x3_q    <= sp[gdsm_pkg::SP_W-1:gdsm_pkg::FRAC_W];
    wc3_q   <= wc2_q;
    wneg3_q <= wneg2_q;

    rng4_q  <= in_range;
    sh4_q   <= yp[2*gdsm_pkg::FRAC_W+gdsm_pkg::SHIFT_W-1:2*gdsm_pkg::FRAC_W];
    idx4_q  <= yp[2*gdsm_pkg::FRAC_W-1 -: gdsm_pkg::EXP_TABLE_BITS];
    wc4_q   <= wc3_q;
    wneg4_q <= wneg3_q;

    e5_q    <= e;
    wc5_q   <= wc4_q;
    wneg5_q <= wneg4_q;

    gain6_q.g_mag <= gp[gdsm_pkg::GP_W-1:gdsm_pkg::GAIN_SHIFT];
    gain6_q.g_neg <= wneg5_q;
  end

  assign valid_o = valid_q[gdsm_pkg::GAIN_STAGES-1];
  assign gain_o  = gain6_q;

endmodule

### sv/gdsm_cplx_mul.sv
// ----------------------------------------------------------------------------
// Complex multiply by j*G
// Three-stage split multiply of the bin parts by the gain, followed by
// sign restore and saturation to the 48-bit output range.
// ----------------------------------------------------------------------------
module gdsm_cplx_mul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  gdsm_pkg::gain_t                   gain_i,
  input  gdsm_pkg::bin_t                    bin_i,
  output logic                              valid_o,
  output logic signed [gdsm_pkg::BIN_W-1:0] out_real_o,
  output logic signed [gdsm_pkg::BIN_W-1:0] out_imag_o,
  output logic                              saturated_o
);

  logic [gdsm_pkg::MUL_STAGES-1:0] valid_q, valid_d;

  // Stage 7: partial products on bin halves.
  logic [gdsm_pkg::PP_W-1:0] g_ext;
  logic [gdsm_pkg::PP_W-1:0] re_lo_q, re_hi_q, im_lo_q, im_hi_q;
  logic                      neg_r7_q, neg_i7_q;

  // Stage 8: summed magnitudes, already shifted down by 24.
  logic [gdsm_pkg::PP_W-1:0] mag_r8_q, mag_i8_q;
  logic                      neg_r8_q, neg_i8_q;

  // Stage 9: output registers.
  logic [gdsm_pkg::BIN_W:0]  sat_r, sat_i;
  logic [gdsm_pkg::BIN_W-1:0] out_r_q, out_i_q;
  logic                       sat_q;

  // Returns {clipped, value} for a magnitude and the sign to apply.
  function automatic logic [gdsm_pkg::BIN_W:0] clip(logic [gdsm_pkg::PP_W-1:0] mag,
                                                     logic neg);
    logic [gdsm_pkg::PP_W-1:0]  lim;
    logic [gdsm_pkg::PP_W-1:0]  sel;
    logic                       over;
    logic [gdsm_pkg::BIN_W-1:0] val;
    lim  = neg ? gdsm_pkg::NEG_LIM : gdsm_pkg::POS_LIM;
    over = mag > lim;
    sel  = over ? lim : mag;
    val  = neg ? (~sel[gdsm_pkg::BIN_W-1:0] + 1'b1) : sel[gdsm_pkg::BIN_W-1:0];
    return {over, val};
  endfunction

  assign valid_d = {valid_q[gdsm_pkg::MUL_STAGES-2:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign g_ext = gdsm_pkg::PP_W'(gain_i.g_mag);
  assign sat_r = clip(mag_r8_q, neg_r8_q);
  assign sat_i = clip(mag_i8_q, neg_i8_q);

  always_ff @(posedge clk_i) begin
    re_lo_q  <= gdsm_pkg::PP_W'(bin_i.re_mag[gdsm_pkg::HALF_W-1:0]) * g_ext;
    re_hi_q  <= gdsm_pkg::PP_W'(bin_i.re_mag[gdsm_pkg::BIN_W-1:gdsm_pkg::HALF_W]) * g_ext;
    im_lo_q  <= gdsm_pkg::PP_W'(bin_i.im_mag[gdsm_pkg::HALF_W-1:0]) * g_ext;
    im_hi_q  <= gdsm_pkg::PP_W'(bin_i.im_mag[gdsm_pkg::BIN_W-1:gdsm_pkg::HALF_W]) * g_ext;
    // out_real = -im*G, out_imag = re*G.
    neg_r7_q <= !(bin_i.im_neg ^ gain_i.g_neg);
    neg_i7_q <= bin_i.re_neg ^ gain_i.g_neg;

    mag_r8_q <= im_hi_q + (im_lo_q >> gdsm_pkg::HALF_W);
    mag_i8_q <= re_hi_q + (re_lo_q >> gdsm_pkg::HALF_W);
    neg_r8_q <= neg_r7_q;
    neg_i8_q <= neg_i7_q;

    out_r_q  <= sat_r[gdsm_pkg::BIN_W-1:0];
    out_i_q  <= sat_i[gdsm_pkg::BIN_W-1:0];
    sat_q    <= sat_r[gdsm_pkg::BIN_W] | sat_i[gdsm_pkg::BIN_W];
  end

  assign valid_o     = valid_q[gdsm_pkg::MUL_STAGES-1];
  assign out_real_o  = out_r_q;
  assign out_imag_o  = out_i_q;
  assign saturated_o = sat_q;

  a_valid_delay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o == $past(valid_i, 3))
    else $error("result valid does not follow the gain valid by three cycles");

  a_zero_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && gain_i.g_mag == '0) |-> ##3
      (valid_o && out_real_o == '0 && out_imag_o == '0 && !saturated_o))
    else $error("zero gain did not give a zero, unclipped result");

  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && saturated_o) |->
      (out_real_o == gdsm_pkg::OUT_MAX || out_real_o == gdsm_pkg::OUT_MIN ||
       out_imag_o == gdsm_pkg::OUT_MAX || out_imag_o == gdsm_pkg::OUT_MIN))
    else $error("saturation flagged but no output part sits at a range limit");

endmodule

### sv/gaussian_derivative_spectrum_mul_top.sv
// ----------------------------------------------------------------------------
// Derivative-of-Gaussian spectrum multiplier, top level
// Multiplies one centered spectrum bin per cycle by j*2*pi*W*exp(-k*|f|^2).
// ----------------------------------------------------------------------------
// A request accepted at a clock edge shows its result on out_valid_o after
// passing six gain stages and then three complex-multiply stages.
// Throughput: one request per cycle; busy stays low, every cycle may carry a start.
// The receiver cannot stall: each result is present for exactly one cycle.
// Reset clears every pipeline valid bit and loads the registers with their
// defaults (center 256/256, scale 8478000, direction along columns).
// ----------------------------------------------------------------------------
module gaussian_derivative_spectrum_mul_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  // Request channel.
  input  logic                              start,
  output logic                              busy,
  input  logic [gdsm_pkg::IDX_W-1:0]        column_index_i,
  input  logic [gdsm_pkg::IDX_W-1:0]        row_index_i,
  input  logic signed [gdsm_pkg::BIN_W-1:0] bin_real_i,
  input  logic signed [gdsm_pkg::BIN_W-1:0] bin_imag_i,

  // Result channel.
  output logic                              out_valid_o,
  output logic signed [gdsm_pkg::BIN_W-1:0] out_real_o,
  output logic signed [gdsm_pkg::BIN_W-1:0] out_imag_o,
  output logic                              saturated_o,

  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gdsm_pkg::ADDR_W-1:0]       paddr,
  input  logic [gdsm_pkg::DATA_W-1:0]       pwdata,
  output logic [gdsm_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  gdsm_pkg::cfg_t  cfg;
  gdsm_pkg::gain_t gain;
  gdsm_pkg::bin_t  bin_in;
  gdsm_pkg::bin_t  bin_q [gdsm_pkg::GAIN_STAGES];
  logic            req_accept;
  logic            gain_valid;

  // The pipeline never stalls, so a request is accepted whenever start is high.
  assign busy       = 1'b0;
  assign req_accept = start && !busy;

  gdsm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gdsm_gain_pipe u_gain (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (req_accept),
    .column_index_i (column_index_i),
    .row_index_i    (row_index_i),
    .cfg_i          (cfg),
    .valid_o        (gain_valid),
    .gain_o         (gain)
  );

  // Split each bin part into sign and magnitude on entry. The most negative
  // value maps to a magnitude of 2^47, which still fits the unsigned field.
  always_comb begin
    bin_in.re_neg = bin_real_i[gdsm_pkg::BIN_W-1];
    bin_in.im_neg = bin_imag_i[gdsm_pkg::BIN_W-1];
    bin_in.re_mag = bin_in.re_neg ? (~bin_real_i + 1'b1) : bin_real_i;
    bin_in.im_mag = bin_in.im_neg ? (~bin_imag_i + 1'b1) : bin_imag_i;
  end

  // The bin parts ride alongside the gain pipeline in a plain shift line,
  // so that they meet the gain of the same request at its output.
  always_ff @(posedge clk_i) begin
    bin_q[0] <= bin_in;
    for (int i = 1; i < gdsm_pkg::GAIN_STAGES; i++) begin
      bin_q[i] <= bin_q[i-1];
    end
  end

  gdsm_cplx_mul u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (gain_valid),
    .gain_i      (gain),
    .bin_i       (bin_q[gdsm_pkg::GAIN_STAGES-1]),
    .valid_o     (out_valid_o),
    .out_real_o  (out_real_o),
    .out_imag_o  (out_imag_o),
    .saturated_o (saturated_o)
  );

  // Every accepted request produces exactly one result, a fixed time later.
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_accept |-> ##(gdsm_pkg::LATENCY) out_valid_o)
    else $error("accepted request did not produce a result strobe");

  // A result strobe always traces back to a request accepted earlier.
  a_no_stray_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(req_accept, gdsm_pkg::LATENCY))
    else $error("result strobe does not match an accepted request");

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the derivative-of-Gaussian spectrum multiplier
// Drives centered spectrum bins through the request channel and compares
// every result with a bit-exact predictor kept inside this module. The
// registers are programmed over the APB-style port and read back. Random
// requests cluster around the zero-frequency point so that the exponential
// stays in range.
// ----------------------------------------------------------------------------
module tb;
  import gdsm_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int TAB_BITS    = 8;
  localparam int TAB_SIZE    = 1 << TAB_BITS;

  localparam logic [BIN_W-1:0] BIN_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [BIN_W-1:0] BIN_MIN = 48'h8000_0000_0000;
  localparam logic [BIN_W-1:0] ONE_Q16 = 48'h0000_0001_0000;

  // One filtered bin as it should leave the block.
  typedef struct {
    logic [BIN_W-1:0] re;
    logic [BIN_W-1:0] im;
    logic             sat;
  } bin_result_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic [IDX_W-1:0]         column_index_i;
  logic [IDX_W-1:0]         row_index_i;
  logic signed [BIN_W-1:0]  bin_real_i;
  logic signed [BIN_W-1:0]  bin_imag_i;
  logic                     out_valid_o;
  logic signed [BIN_W-1:0]  out_real_o;
  logic signed [BIN_W-1:0]  out_imag_o;
  logic                     saturated_o;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [ADDR_W-1:0]        paddr;
  logic [DATA_W-1:0]        pwdata;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;

  // Shadow copy of the register file, updated on every write.
  logic [CENTER_W-1:0] ctr_u;
  logic [CENTER_W-1:0] ctr_v;
  logic [SCALE_W-1:0]  falloff_scale;
  logic                along_rows;

  // 2^(-i/256) in Q.32, rebuilt here from the definition of the lookup.
  logic [63:0] falloff_tab [TAB_SIZE];

  bin_result_t pending_bins[$];
  int          errors;
  int          cycle_count;
  bit          steady;

  gaussian_derivative_spectrum_mul_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .column_index_i (column_index_i),
    .row_index_i    (row_index_i),
    .bin_real_i     (bin_real_i),
    .bin_imag_i     (bin_imag_i),
    .out_valid_o    (out_valid_o),
    .out_real_o     (out_real_o),
    .out_imag_o     (out_imag_o),
    .saturated_o    (saturated_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // A stuck handshake or a lost result would otherwise hang the run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[gaussian_derivative_spectrum_mul_top] ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 40) begin
      $display("%0t mismatch: %s", $time, msg);
    end
  endtask

  // Scales one magnitude by the gain (Q.24), clips it to the signed 48-bit
  // range and applies the sign. A zero product stays zero whatever the sign.
  function automatic logic [BIN_W-1:0] apply_gain(input logic [BIN_W-1:0] mag,
                                                  input logic [63:0] gain,
                                                  input logic neg,
                                                  output logic clipped);
    logic [127:0] prod;
    logic [127:0] lim;
    clipped = 1'b0;
    prod = ({80'd0, mag} * {64'd0, gain}) >> 24;
    if (prod == 0) begin
      return '0;
    end
    lim = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
    if (prod > lim) begin
      prod    = lim;
      clipped = 1'b1;
    end
    return neg ? (48'd0 - prod[BIN_W-1:0]) : prod[BIN_W-1:0];
  endfunction

  // Bit-exact prediction of one filtered bin under the current registers.
  function automatic bin_result_t filter_bin(input logic [IDX_W-1:0] col,
                                             input logic [IDX_W-1:0] row,
                                             input logic [BIN_W-1:0] re,
                                             input logic [BIN_W-1:0] im);
    logic [IDX_W-1:0] c;
    logic [IDX_W-1:0] r;
    logic [BIN_W-1:0] re_mag;
    logic [BIN_W-1:0] im_mag;
    logic             u_neg;
    logic             v_neg;
    logic             g_neg;
    logic [63:0]      u_mag;
    logic [63:0]      v_mag;
    logic [63:0]      dist2;
    logic [63:0]      kd;
    logic [63:0]      octaves;
    logic [63:0]      falloff;
    logic [63:0]      w_mag;
    logic [63:0]      gain;
    logic             clip_re;
    logic             clip_im;
    bin_result_t      res;
    // Indices past the last row or column of the largest spectrum are clamped.
    c = (col > IDX_W'(MAX_SIDE - 1)) ? IDX_W'(MAX_SIDE - 1) : col;
    r = (row > IDX_W'(MAX_SIDE - 1)) ? IDX_W'(MAX_SIDE - 1) : row;
    re_mag = re[BIN_W-1] ? (48'd0 - re) : re;
    im_mag = im[BIN_W-1] ? (48'd0 - im) : im;
    u_neg  = c < ctr_u;
    v_neg  = r < ctr_v;
    u_mag  = u_neg ? 64'(ctr_u - c) : 64'(c - ctr_u);
    v_mag  = v_neg ? 64'(ctr_v - r) : 64'(r - ctr_v);
    dist2  = u_mag * u_mag + v_mag * v_mag;
    kd      = (64'(falloff_scale) * dist2) >> 16;
    octaves = (kd * 64'd94548) >> 16;
    // The exponential is flushed to zero once it is shifted by 32 or more.
    falloff = 64'd0;
    if ((octaves >> 16) < 64'd32) begin
      falloff = falloff_tab[octaves[15:16-TAB_BITS]] >> (octaves >> 16);
    end
    w_mag = along_rows ? v_mag : u_mag;
    g_neg = along_rows ? v_neg : u_neg;
    gain  = (w_mag * falloff * 64'd411775) >> 24;
    // Multiplying by j*G: real = -im*G, imag = re*G.
    res.re  = apply_gain(im_mag, gain, ~(im[BIN_W-1] ^ g_neg), clip_re);
    res.im  = apply_gain(re_mag, gain, re[BIN_W-1] ^ g_neg, clip_im);
    res.sat = clip_re | clip_im;
    return res;
  endfunction

  // Every result must match the oldest prediction still waiting.
  always @(posedge clk_i) begin
    bin_result_t want;
    if (rst_ni && out_valid_o === 1'b1) begin
      if (pending_bins.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = pending_bins.pop_front();
        if (out_real_o !== want.re) begin
          report_mismatch($sformatf("out_real %h, want %h", out_real_o, want.re));
        end
        if (out_imag_o !== want.im) begin
          report_mismatch($sformatf("out_imag %h, want %h", out_imag_o, want.im));
        end
        if (saturated_o !== want.sat) begin
          report_mismatch($sformatf("saturated %b, want %b", saturated_o, want.sat));
        end
      end
    end
  end

  // Sends one request, after a random gap unless a steady stretch is on.
  // start stays high when the next request follows without a gap.
  task automatic send_bin(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row,
                          input logic [BIN_W-1:0] re, input logic [BIN_W-1:0] im);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start          <= 1'b1;
    column_index_i <= col;
    row_index_i    <= row;
    bin_real_i     <= re;
    bin_imag_i     <= im;
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_bins.push_back(filter_bin(col, row, re, im));
  endtask

  // Drops start and waits until every outstanding request has come back.
  task automatic wait_idle();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk_i);
  endtask

  // Optionally writes a register, then reads it back against the shadow copy.
  task automatic access_reg(input reg_idx_e idx, input logic wr,
                            input logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] held;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (wr) begin
      case (idx)
        REG_CENTER_U:  ctr_u         = val[CENTER_W-1:0];
        REG_CENTER_V:  ctr_v         = val[CENTER_W-1:0];
        REG_EXP_SCALE: falloff_scale = val;
        REG_DIRECTION: along_rows    = val[0];
        default: ;
      endcase
      @(negedge clk_i);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (pready !== 1'b1);
    end
    case (idx)
      REG_CENTER_U:  held = DATA_W'(ctr_u);
      REG_CENTER_V:  held = DATA_W'(ctr_v);
      REG_EXP_SCALE: held = falloff_scale;
      default:       held = DATA_W'(along_rows);
    endcase
    if (prdata !== held) begin
      report_mismatch($sformatf("register %s reads %h, want %h", idx.name(), prdata, held));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_filter(input logic [CENTER_W-1:0] cu, input logic [CENTER_W-1:0] cv,
                            input logic [SCALE_W-1:0] k, input logic dir);
    wait_idle();
    access_reg(REG_CENTER_U, 1'b1, DATA_W'(cu));
    access_reg(REG_CENTER_V, 1'b1, DATA_W'(cv));
    access_reg(REG_EXP_SCALE, 1'b1, k);
    access_reg(REG_DIRECTION, 1'b1, DATA_W'(dir));
  endtask

  // Signed bin part: mostly random values of every magnitude, some extremes.
  function automatic logic [BIN_W-1:0] random_part();
    logic signed [BIN_W-1:0] v;
    int                      pick;
    pick = $urandom_range(0, 9);
    v    = BIN_W'({$urandom, $urandom});
    if (pick < 7) begin
      v = v >>> $urandom_range(0, BIN_W - 1);
    end else if (pick == 9) begin
      case ($urandom_range(0, 4))
        0:       v = BIN_MAX;
        1:       v = BIN_MIN;
        2:       v = '0;
        3:       v = 48'd1;
        default: v = '1;
      endcase
    end
    return v;
  endfunction

  // Index mostly within a random reach of the center, where the exponential
  // does not flush, and sometimes anywhere in the 12-bit range.
  function automatic logic [IDX_W-1:0] random_index(input logic [CENTER_W-1:0] ctr);
    int reach;
    int pos;
    if ($urandom_range(0, 3) == 0) begin
      return IDX_W'($urandom);
    end
    reach = 1 << $urandom_range(0, 8);
    pos   = int'(ctr) + int'($urandom_range(0, 2 * reach)) - reach;
    if (pos < 0) pos = 0;
    if (pos > MAX_SIDE - 1) pos = MAX_SIDE - 1;
    return IDX_W'(pos);
  endfunction

  task automatic test_reset_defaults();
    access_reg(REG_CENTER_U, 1'b0, '0);
    access_reg(REG_CENTER_V, 1'b0, '0);
    access_reg(REG_EXP_SCALE, 1'b0, '0);
    access_reg(REG_DIRECTION, 1'b0, '0);
  endtask

  // Extremes of each register; upper bits of the data word must be dropped.
  task automatic test_registers();
    access_reg(REG_CENTER_U, 1'b1, 32'hFFFF_FFFF);
    access_reg(REG_CENTER_V, 1'b1, 32'h0000_0000);
    access_reg(REG_CENTER_V, 1'b1, 32'hFFFF_F000);
    access_reg(REG_EXP_SCALE, 1'b1, 32'hFFFF_FFFF);
    access_reg(REG_EXP_SCALE, 1'b1, 32'h0000_0000);
    access_reg(REG_DIRECTION, 1'b1, 32'hFFFF_FFFE);
    access_reg(REG_DIRECTION, 1'b1, 32'h0000_0001);
  endtask

  task automatic test_directed();
    set_filter(12'd256, 12'd256, 32'd8478000, 1'b0);
    // Zero frequency, and U = 0 along columns: the gain vanishes.
    send_bin(12'd256, 12'd256, ONE_Q16, 48'd0 - ONE_Q16);
    send_bin(12'd256, 12'd300, BIN_MAX, BIN_MIN);
    // Just either side of the center, where the sign of U flips.
    send_bin(12'd257, 12'd256, ONE_Q16, 48'd0);
    send_bin(12'd255, 12'd256, 48'd0, ONE_Q16);
    send_bin(12'd266, 12'd261, 48'h0000_1234_5678, 48'hFFFF_8765_4321);
    send_bin(12'd300, 12'd256, BIN_MIN, BIN_MAX);
    // Far corners: the exponent runs out of range and flushes to zero.
    send_bin(12'd0, 12'd0, BIN_MAX, BIN_MIN);
    send_bin(12'd4095, 12'd4095, BIN_MIN, BIN_MAX);
    // Derivative along rows.
    set_filter(12'd256, 12'd256, 32'd8478000, 1'b1);
    send_bin(12'd256, 12'd300, ONE_Q16, ONE_Q16);
    send_bin(12'd256, 12'd200, 48'd0 - ONE_Q16, ONE_Q16);
    send_bin(12'd300, 12'd256, BIN_MAX, BIN_MAX);
    // Without decay the gain reaches 2*pi*W and full-scale bins clip.
    set_filter(12'd256, 12'd256, 32'd0, 1'b0);
    send_bin(12'd257, 12'd256, BIN_MAX, BIN_MIN);
    send_bin(12'd255, 12'd256, BIN_MIN, BIN_MAX);
    send_bin(12'd257, 12'd257, 48'd0, 48'd0);
    send_bin(12'd4095, 12'd0, 48'd1, 48'hFFFF_FFFF_FFFF);
    set_filter(12'd0, 12'd4095, 32'd0, 1'b1);
    send_bin(12'd4095, 12'd0, BIN_MAX, BIN_MAX);
    send_bin(12'd0, 12'd4095, BIN_MAX, BIN_MIN);
    // Largest decay: only the nearest neighbors survive.
    set_filter(12'd2048, 12'd2048, 32'hFFFF_FFFF, 1'b0);
    send_bin(12'd2049, 12'd2048, BIN_MAX, BIN_MIN);
    send_bin(12'd2047, 12'd2049, BIN_MIN, BIN_MAX);
    send_bin(12'd2058, 12'd2048, BIN_MAX, BIN_MAX);
    wait_idle();
  endtask

  // Six register settings, two hundred random requests under each.
  // Every fortieth request may start a stretch without any gap.
  task automatic test_random_stream();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_filter(12'd256, 12'd256, 32'd8478000, 1'b0);
        1: set_filter(12'd0, 12'd0, 32'($urandom_range(0, 100000)), 1'b1);
        2: set_filter(12'd4095, 12'd4095, 32'hFFFF_FFFF, 1'b0);
        3: set_filter(12'($urandom), 12'($urandom), 32'($urandom_range(0, 2000000)),
                      1'($urandom));
        4: set_filter(12'($urandom), 12'($urandom), 32'd0, 1'($urandom));
        default: set_filter(12'($urandom), 12'($urandom),
                            $urandom >> $urandom_range(0, 31), 1'($urandom));
      endcase
      for (int k = 0; k < 200; k++) begin
        if (k % 40 == 0) begin
          steady = ($urandom_range(0, 2) == 0);
        end
        send_bin(random_index(ctr_u), random_index(ctr_v), random_part(), random_part());
      end
      steady = 1'b0;
    end
    wait_idle();
  endtask

  initial begin
    logic [63:0] step;
    logic [63:0] radicand;
    logic [63:0] root;
    logic [63:0] cand;
    rst_ni         = 1'b0;
    start          = 1'b0;
    column_index_i = '0;
    row_index_i    = '0;
    bin_real_i     = '0;
    bin_imag_i     = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    errors         = 0;
    cycle_count    = 0;
    steady         = 1'b0;
    ctr_u          = 12'd256;
    ctr_v          = 12'd256;
    falloff_scale  = 32'd8478000;
    along_rows     = 1'b0;

    // The table step is the 256th root of one half: eight floored square
    // roots of 0.5 in Q.32, each found bit by bit from the top.
    step = 64'd1 << 31;
    for (int i = 0; i < TAB_BITS; i++) begin
      radicand = step << 32;
      root     = 64'd0;
      for (int b = 31; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (cand * cand <= radicand) root = cand;
      end
      step = root;
    end
    falloff_tab[0] = 64'd1 << 32;
    for (int i = 1; i < TAB_SIZE; i++) begin
      falloff_tab[i] = (falloff_tab[i-1] * step + (64'd1 << 31)) >> 32;
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_registers();
    test_directed();
    test_random_stream();

    // Let any stray result surface before judging the run.
    wait_idle();
    repeat (LATENCY + 4) @(posedge clk_i);
    if (errors == 0) begin
      $display("[gaussian_derivative_spectrum_mul_top] OK");
    end else begin
      $display("[gaussian_derivative_spectrum_mul_top] ERROR");
    end
    $finish;
  end

endmodule
